/* src/pad_pkg.sv */
package pad_pkg;

    localparam int unsigned FULL_SCALE = 100;
    localparam int unsigned MAX_DIGITS = 9;

    localparam int unsigned LEVEL_W = 7;
    localparam int unsigned DIGIT_W = 4;

    // item kinds
    localparam logic [1:0] FUNC_TICK       = 2'd0;
    localparam logic [1:0] FUNC_ZERO_CROSS = 2'd1;
    localparam logic [1:0] FUNC_KEY        = 2'd2;
    localparam logic [1:0] FUNC_UNUSED     = 2'd3;

    // decoded key codes beyond the digits
    localparam logic [3:0] KEY_UP    = 4'd10;
    localparam logic [3:0] KEY_DOWN  = 4'd11;
    localparam logic [3:0] KEY_ENTER = 4'd15;
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] key_code;
    } in_word_t;

    typedef struct packed {
        logic               gate_fire;
        logic [LEVEL_W-1:0] level;
        logic               entry_error;
    } out_word_t;

    typedef logic [3:0] key_map_t [16];

    localparam key_map_t KEY_MAP = '{
        4'd1, 4'd2, 4'd3, 4'd10, 4'd4, 4'd5, 4'd6, 4'd11,
        4'd7, 4'd8, 4'd9, 4'd12, 4'd13, 4'd0, 4'd14, 4'd15
    };

    function automatic logic [3:0] key_decode(input logic [3:0] raw);
        key_decode = KEY_MAP[raw];
    endfunction

endpackage

/* src/pad_keypad.sv */
module pad_keypad (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        key_en,
    input  logic [3:0]                  key_code,
    output logic [pad_pkg::LEVEL_W-1:0] intensity,
    output logic [pad_pkg::LEVEL_W-1:0] level_next,
    output logic                        entry_error
);

    localparam logic [pad_pkg::LEVEL_W-1:0] FULL = pad_pkg::LEVEL_W'(pad_pkg::FULL_SCALE);
    localparam logic [pad_pkg::LEVEL_W-1:0] SAT  = pad_pkg::LEVEL_W'(pad_pkg::FULL_SCALE + 1);
    localparam logic [pad_pkg::DIGIT_W-1:0] MAXD = pad_pkg::DIGIT_W'(pad_pkg::MAX_DIGITS);

    logic [pad_pkg::LEVEL_W-1:0] intensity_reg, intensity_next;
    logic [pad_pkg::LEVEL_W-1:0] entry_value_reg, entry_value_next;
    logic [pad_pkg::DIGIT_W-1:0] entry_digits_reg, entry_digits_next;
    logic [3:0]                  k;
    logic [pad_pkg::LEVEL_W+3:0] shifted;
    logic                        err;

    always_comb
    begin
        k                 = pad_pkg::key_decode(key_code);
        // value * 10 + digit, as (value << 3) + (value << 1)
        shifted           = {entry_value_reg, 3'b000} + {2'b00, entry_value_reg, 1'b0}
                            + {{pad_pkg::LEVEL_W{1'b0}}, k};
        intensity_next    = intensity_reg;
        entry_value_next  = entry_value_reg;
        entry_digits_next = entry_digits_reg;
        err               = 1'b0;
        if (key_en)
        begin
            if (k <= pad_pkg::KEY_DIGIT_MAX)
            begin
                if (entry_digits_reg < MAXD)
                begin
                    entry_digits_next = entry_digits_reg + 1'b1;
                    if (shifted > {4'b0000, SAT})
                        entry_value_next = SAT;
                    else
                        entry_value_next = shifted[pad_pkg::LEVEL_W-1:0];
                end
            end
            else
            begin
                case (k)
                    pad_pkg::KEY_ENTER:
                    begin
                        if (entry_digits_reg != '0)
                        begin
                            if (entry_value_reg <= FULL)
                                intensity_next = entry_value_reg;
                            else
                            begin
                                intensity_next = FULL;
                                err            = 1'b1;
                            end
                            entry_digits_next = '0;
                            entry_value_next  = '0;
                        end
                    end
                    pad_pkg::KEY_UP:
                    begin
                        if (intensity_reg < FULL)
                            intensity_next = intensity_reg + 1'b1;
                    end
                    pad_pkg::KEY_DOWN:
                    begin
                        if (intensity_reg != '0)
                            intensity_next = intensity_reg - 1'b1;
                    end
                    default:
                    begin
                        intensity_next = intensity_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intensity_reg    <= '0;
            entry_value_reg  <= '0;
            entry_digits_reg <= '0;
        end
        else
        begin
            intensity_reg    <= intensity_next;
            entry_value_reg  <= entry_value_next;
            entry_digits_reg <= entry_digits_next;
        end
    end

    assign intensity   = intensity_reg;
    assign level_next  = intensity_next;
    assign entry_error = err;

endmodule

/* src/phase_angle_dimmer_keypad.sv */
// channel | signals                          | word
// --------+----------------------------------+-----------------------------------
// input   | in_valid, in_ready, in_word      | func, key_code
// output  | out_valid, out_ready, out_word   | gate_fire, level, entry_error
//
// one word per clock while the output is not stalled: an accepted word is held in the
// input register, then its result is loaded into the output register.
// the output register frees up in the cycle it is taken, which sets the rate.
// a stalled output holds the input register too; in_ready drops only when both are full.
// rst_n clears the phase counter, gate, level, entry and both valid flags.
module phase_angle_dimmer_keypad (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pad_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output pad_pkg::out_word_t out_word
);

    localparam logic [pad_pkg::LEVEL_W-1:0] FULL = pad_pkg::LEVEL_W'(pad_pkg::FULL_SCALE);

    logic                        in_valid_reg;
    pad_pkg::in_word_t           in_word_reg;
    logic                        out_valid_reg;
    pad_pkg::out_word_t          out_word_reg, out_word_next;
    logic [pad_pkg::LEVEL_W-1:0] phase_reg, phase_next;
    logic                        gate_reg, gate_next;
    logic                        advance;
    logic                        step;
    logic                        key_en;
    logic [pad_pkg::LEVEL_W-1:0] intensity;
    logic [pad_pkg::LEVEL_W-1:0] level_next;
    logic                        entry_error;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;
    assign key_en   = step && (in_word_reg.func == pad_pkg::FUNC_KEY);

    pad_keypad u_keypad (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_en      (key_en),
        .key_code    (in_word_reg.key_code),
        .intensity   (intensity),
        .level_next  (level_next),
        .entry_error (entry_error)
    );

    always_comb
    begin
        phase_next = phase_reg;
        gate_next  = gate_reg;
        case (in_word_reg.func)
            pad_pkg::FUNC_TICK:
            begin
                if (phase_reg <= FULL)
                    phase_next = phase_reg + 1'b1;
                else
                    phase_next = '0;
                // intensity never exceeds full scale, so no underflow
                gate_next = (phase_next > (FULL - intensity));
            end
            pad_pkg::FUNC_ZERO_CROSS:
            begin
                phase_next = '0;
                gate_next  = 1'b0;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
        out_word_next.gate_fire   = gate_next;
        out_word_next.level       = level_next;
        out_word_next.entry_error = entry_error;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            gate_reg      <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (step)
            begin
                phase_reg <= phase_next;
                gate_reg  <= gate_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_word_reg <= in_word;
        if (step)
            out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

/* src/pad_checker.sv */
module pad_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input pad_pkg::out_word_t out_word
);

    localparam logic [pad_pkg::LEVEL_W-1:0] FULL = pad_pkg::LEVEL_W'(pad_pkg::FULL_SCALE);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // an empty output side never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.level <= FULL)
        else $error("level above full scale");

    // a rejected entry forces full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.entry_error |-> out_word.level == FULL)
        else $error("entry error without full scale level");

    // a word accepted into an idle block shows up after the input and output registers
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
        else $error("accepted word produced no result");

endmodule

bind phase_angle_dimmer_keypad pad_checker u_pad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;
    localparam int LONG_HOLD = 60;
    localparam int LONG_HOLD_AT = 200;

    typedef struct {
        pad_pkg::in_word_t word;
        int                gap;
        bit                hold;
    } key_event_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    pad_pkg::in_word_t  in_word = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    pad_pkg::out_word_t out_word;

    phase_angle_dimmer_keypad DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always #2 clk = ~clk;

    // mirror of the dimmer state
    logic [6:0] m_phase = '0;
    logic       m_gate = 1'b0;
    logic [6:0] m_level = '0;
    logic [6:0] m_entry = '0;
    logic [3:0] m_digits = '0;

    key_event_t         queued_events[$];
    pad_pkg::out_word_t due_outputs[$];

    int  fail_count = 0;
    int  words_in = 0;
    int  words_out = 0;
    int  gate_highs = 0;
    int  rejected_entries = 0;
    bit  calm_send = 1'b0;
    bit  hold_next = 1'b0;

    function automatic logic [3:0] keypad_lookup(input logic [3:0] raw);
        case (raw)
            4'd0:    return 4'd1;
            4'd1:    return 4'd2;
            4'd2:    return 4'd3;
            4'd3:    return pad_pkg::KEY_UP;
            4'd4:    return 4'd4;
            4'd5:    return 4'd5;
            4'd6:    return 4'd6;
            4'd7:    return pad_pkg::KEY_DOWN;
            4'd8:    return 4'd7;
            4'd9:    return 4'd8;
            4'd10:   return 4'd9;
            4'd11:   return 4'd12;
            4'd12:   return 4'd13;
            4'd13:   return 4'd0;
            4'd14:   return 4'd14;
            default: return pad_pkg::KEY_ENTER;
        endcase
    endfunction

    function automatic logic [3:0] raw_for_key(input logic [3:0] k);
        for (int r = 0; r < 16; r++)
            if (keypad_lookup(4'(r)) == k)
                return 4'(r);
        return 4'd0;
    endfunction

    function automatic pad_pkg::out_word_t advance_dimmer(input pad_pkg::in_word_t w);
        pad_pkg::out_word_t r;
        logic [3:0]         k;
        logic               err;
        int                 v;
        err = 1'b0;
        if (w.func == pad_pkg::FUNC_TICK) begin
            if (m_phase <= pad_pkg::FULL_SCALE)
                m_phase = m_phase + 7'd1;
            else
                m_phase = '0;
            m_gate = (int'(m_phase) > int'(pad_pkg::FULL_SCALE) - int'(m_level));
        end else if (w.func == pad_pkg::FUNC_ZERO_CROSS) begin
            m_phase = '0;
            m_gate = 1'b0;
        end else if (w.func == pad_pkg::FUNC_KEY) begin
            k = keypad_lookup(w.key_code);
            if (k <= pad_pkg::KEY_DIGIT_MAX) begin
                if (m_digits < pad_pkg::MAX_DIGITS) begin
                    v = int'(m_entry) * 10 + int'(k);
                    if (v > int'(pad_pkg::FULL_SCALE) + 1)
                        v = int'(pad_pkg::FULL_SCALE) + 1;
                    m_entry = 7'(v);
                    m_digits = m_digits + 4'd1;
                end
            end else if (k == pad_pkg::KEY_ENTER) begin
                if (m_digits != 0) begin
                    if (m_entry <= pad_pkg::FULL_SCALE) begin
                        m_level = m_entry;
                    end else begin
                        m_level = 7'(pad_pkg::FULL_SCALE);
                        err = 1'b1;
                    end
                    m_entry = '0;
                    m_digits = '0;
                end
            end else if (k == pad_pkg::KEY_UP) begin
                if (m_level < pad_pkg::FULL_SCALE)
                    m_level = m_level + 7'd1;
            end else if (k == pad_pkg::KEY_DOWN) begin
                if (m_level >= 1)
                    m_level = m_level - 7'd1;
            end
        end
        r.gate_fire = m_gate;
        r.level = m_level;
        r.entry_error = err;
        return r;
    endfunction

    task automatic queue_word(input logic [1:0] f, input logic [3:0] k);
        key_event_t e;
        e.word = pad_pkg::in_word_t'{func: f, key_code: k};
        e.gap = calm_send ? 0 : $urandom_range(0, 5);
        e.hold = hold_next;
        hold_next = 1'b0;
        if ($urandom_range(0, 40) == 0)
            calm_send = !calm_send;
        queued_events.push_back(e);
    endtask

    task automatic queue_key(input logic [3:0] k);
        queue_word(pad_pkg::FUNC_KEY, raw_for_key(k));
    endtask

    task automatic queue_entry(input int n, input bit close);
        for (int i = 0; i < n; i++)
            queue_key(4'($urandom_range(0, 9)));
        if (close)
            queue_key(pad_pkg::KEY_ENTER);
    endtask

    task automatic build_stimulus;
        int pick;
        int n;
        // directed: reset state, ignored codes, limits of the entry and of the level
        queue_word(pad_pkg::FUNC_UNUSED, 4'hf);
        queue_key(pad_pkg::KEY_ENTER);
        queue_key(pad_pkg::KEY_DOWN);
        queue_word(pad_pkg::FUNC_TICK, 4'h0);
        queue_key(4'd1);
        queue_key(4'd0);
        queue_key(4'd1);
        queue_key(pad_pkg::KEY_ENTER);
        queue_key(pad_pkg::KEY_UP);
        queue_word(pad_pkg::FUNC_TICK, 4'ha);
        queue_word(pad_pkg::FUNC_ZERO_CROSS, 4'h5);
        queue_word(pad_pkg::FUNC_KEY, 4'd11);
        queue_word(pad_pkg::FUNC_KEY, 4'd12);
        queue_word(pad_pkg::FUNC_KEY, 4'd14);
        for (int i = 0; i < 10; i++)
            queue_key(4'd9);
        queue_key(pad_pkg::KEY_ENTER);

        while (queued_events.size() < 600) begin
            if (queued_events.size() > 300 && queued_events.size() < 310)
                hold_next = 1'b1;
            else if ($urandom_range(0, 60) == 0)
                hold_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                if ($urandom_range(0, 2) == 0) begin
                    queue_key(4'd1);
                    queue_key(4'd0);
                    queue_entry($urandom_range(0, 1), 1'b1);
                end else begin
                    queue_entry($urandom_range(1, 3), 1'b1);
                end
            end else if (pick < 50) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 115)
                                                : $urandom_range(1, 30);
                for (int i = 0; i < n; i++)
                    queue_word(pad_pkg::FUNC_TICK, 4'($urandom));
            end else if (pick < 60) begin
                queue_word(pad_pkg::FUNC_ZERO_CROSS, 4'($urandom));
            end else if (pick < 75) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    queue_key($urandom_range(0, 1) ? pad_pkg::KEY_UP : pad_pkg::KEY_DOWN);
            end else if (pick < 85) begin
                queue_word(2'($urandom_range(0, 3)), 4'($urandom));
            end else if (pick < 93) begin
                // entry left open, then something unrelated
                queue_entry($urandom_range(1, 4), 1'b0);
                queue_word(2'($urandom_range(0, 3)), 4'($urandom));
            end else begin
                queue_entry($urandom_range(8, 12), 1'b1);
            end
        end
    endtask

    // sender
    int send_wait = 0;

    always @(posedge clk or negedge rst_n) begin : drive
        key_event_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_wait <= 0;
        end else begin
            if (in_valid && in_ready) begin
                due_outputs.push_back(advance_dimmer(in_word));
                words_in++;
            end
            if (!in_valid || in_ready) begin
                if (queued_events.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (queued_events[0].hold && due_outputs.size() != 0) begin
                    in_valid <= 1'b0;
                end else if (send_wait < queued_events[0].gap) begin
                    send_wait <= send_wait + 1;
                    in_valid <= 1'b0;
                end else begin
                    nxt = queued_events.pop_front();
                    in_word <= nxt.word;
                    in_valid <= 1'b1;
                    send_wait <= 0;
                end
            end
        end
    end

    // receiver and checker
    int  stall_left = 0;
    bit  calm_recv = 1'b0;

    always @(posedge clk or negedge rst_n) begin : watch
        pad_pkg::out_word_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                words_out++;
                if (due_outputs.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected word gate %0b level %0d err %0b", $time,
                             out_word.gate_fire, out_word.level, out_word.entry_error);
                end else begin
                    want = due_outputs.pop_front();
                    if (out_word.gate_fire !== want.gate_fire
                        || out_word.level !== want.level
                        || out_word.entry_error !== want.entry_error) begin
                        fail_count++;
                        $display("%0t: expected gate %0b level %0d err %0b, got %0b %0d %0b",
                                 $time, want.gate_fire, want.level, want.entry_error,
                                 out_word.gate_fire, out_word.level, out_word.entry_error);
                    end
                    if (want.gate_fire)
                        gate_highs++;
                    if (want.entry_error)
                        rejected_entries++;
                end
                // one long hold-off so the block backs up into its input
                if (words_out == LONG_HOLD_AT)
                    stall_left = LONG_HOLD;
                else
                    stall_left = calm_recv ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 31) == 0)
                    calm_recv = !calm_recv;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_ready <= (stall_left == 0);
        end
    end

    // watchdog on cycles without any transfer
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d words queued, %0d expected",
                     queued_events.size(), due_outputs.size());
            $display("phase_angle_dimmer_keypad: mismatch");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // sample between edges so the sender's updates have settled
        while (queued_events.size() != 0 || in_valid || due_outputs.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        $display("%0d words sent, %0d checked, %0d with gate high, %0d rejected entries",
                 words_in, words_out, gate_highs, rejected_entries);
        $display("covered ticks, zero crossings, keypad entry, level steps and unused codes");
        if (fail_count == 0)
            $display("phase_angle_dimmer_keypad: match");
        else
            $display("phase_angle_dimmer_keypad: mismatch");
        $finish;
    end

endmodule
